>>> src/psu_pkg.sv
// shared types, codes and constants for the positional stack unit
package psu_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned WIDTH_DEF = 32;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned FILL_W    = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_TOP    = 3'd0,
    OP_POP_TOP     = 3'd1,
    OP_PUSH_BOTTOM = 3'd2,
    OP_POP_BOTTOM  = 3'd3,
    OP_INSERT_AT   = 3'd4,
    OP_DELETE_AT   = 3'd5,
    OP_READ_AT     = 3'd6,
    OP_READ_BOTTOM = 3'd7
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_RESULT
  } state_e;

  typedef enum logic [1:0] {
    RD_BELOW,
    RD_ABOVE,
    RD_IDX,
    RD_TOP
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_MOVE,
    WR_VAL_IDX,
    WR_VAL_TOP
  } wr_sel_e;

  typedef struct packed {
    logic    accept;
    logic    ptr_init_top;
    logic    ptr_init_idx;
    logic    ptr_dec;
    logic    ptr_inc;
    logic    mem_rd;
    rd_sel_e rd_sel;
    logic    mem_wr;
    wr_sel_e wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_status;
    status_e status;
    logic    use_rdata;
    logic    res_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic empty;
    logic full;
    logic pos_ok;
    logic up_more;
    logic dn_more;
    logic out_free;
  } stat_t;

endpackage

>>> src/psu_ram.sv
// generic single write port, single read port ram with registered read
module psu_ram #(
  parameter int unsigned WIDTH = psu_pkg::WIDTH_DEF,
  parameter int unsigned DEPTH = psu_pkg::DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/psu_dp.sv
// datapath: request registers, count, move pointer, slot memory and result register
module psu_dp #(
  parameter int unsigned DEPTH = psu_pkg::DEPTH_DEF,
  parameter int unsigned WIDTH = psu_pkg::WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  psu_pkg::op_e                 in_op_i,
  input  logic signed [psu_pkg::DATA_W-1:0] in_value_i,
  input  logic [psu_pkg::POS_W-1:0]    in_pos_i,
  input  logic                         out_ready_i,
  input  psu_pkg::cmd_t                cmd_i,
  output psu_pkg::stat_t               stat_o,
  output logic                         out_valid_o,
  output logic [psu_pkg::DATA_W-1:0]   out_data_o,
  output psu_pkg::status_e             out_status_o,
  output logic [psu_pkg::FILL_W-1:0]   out_fill_o
);

  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned CNT_W1 = CNT_W + 1;
  localparam int unsigned CMP_W  = (CNT_W > psu_pkg::POS_W) ? CNT_W : psu_pkg::POS_W;

  psu_pkg::op_e                op_q;
  logic [WIDTH-1:0]            val_q;
  logic [psu_pkg::POS_W-1:0]   pos_q;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [CNT_W-1:0]            ptr_q, ptr_d;
  psu_pkg::status_e            res_st_q;
  logic                        res_rd_q;
  logic                        out_valid_q, out_valid_d;
  logic [psu_pkg::DATA_W-1:0]  out_data_q;
  psu_pkg::status_e            out_status_q;
  logic [psu_pkg::FILL_W-1:0]  out_fill_q;

  logic [CNT_W-1:0]            idx;
  logic [CNT_W-1:0]            raddr_full, waddr_full;
  logic [WIDTH-1:0]            wdata;
  logic [WIDTH-1:0]            rdata;
  logic signed [WIDTH-1:0]     rdata_s;

  always_comb begin
    if (op_q inside {psu_pkg::OP_PUSH_BOTTOM, psu_pkg::OP_POP_BOTTOM,
                     psu_pkg::OP_READ_BOTTOM}) begin
      idx = '0;
    end else begin
      idx = CNT_W'(pos_q) - CNT_W'(1);
    end
  end

  assign stat_o.op       = op_q;
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = (count_q == CNT_W'(DEPTH));
  assign stat_o.pos_ok   = (pos_q != '0) && (CMP_W'(pos_q) <= CMP_W'(count_q));
  assign stat_o.up_more  = (ptr_q > idx);
  assign stat_o.dn_more  = ((CNT_W1'(ptr_q) + CNT_W1'(1)) < CNT_W1'(count_q));
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // memory addressing
  always_comb begin
    case (cmd_i.rd_sel)
      psu_pkg::RD_BELOW: raddr_full = ptr_q - CNT_W'(1);
      psu_pkg::RD_ABOVE: raddr_full = ptr_q + CNT_W'(1);
      psu_pkg::RD_IDX:   raddr_full = idx;
      psu_pkg::RD_TOP:   raddr_full = count_q - CNT_W'(1);
      default:           raddr_full = idx;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      psu_pkg::WR_MOVE: begin
        waddr_full = ptr_q;
        wdata      = rdata;
      end
      psu_pkg::WR_VAL_IDX: begin
        waddr_full = idx;
        wdata      = val_q;
      end
      psu_pkg::WR_VAL_TOP: begin
        waddr_full = count_q;
        wdata      = val_q;
      end
      default: begin
        waddr_full = idx;
        wdata      = val_q;
      end
    endcase
  end

  psu_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_wr),
    .waddr_i (waddr_full[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (cmd_i.mem_rd),
    .raddr_i (raddr_full[AW-1:0]),
    .rdata_o (rdata)
  );

  assign rdata_s = rdata;

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_init_top) begin
      ptr_d = count_q;
    end else if (cmd_i.ptr_init_idx) begin
      ptr_d = idx;
    end else if (cmd_i.ptr_dec) begin
      ptr_d = ptr_q - CNT_W'(1);
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.accept) begin
      op_q  <= in_op_i;
      val_q <= WIDTH'(in_value_i);
      pos_q <= in_pos_i;
    end
    if (cmd_i.set_status) begin
      res_st_q <= cmd_i.status;
      res_rd_q <= cmd_i.use_rdata;
    end
    if (cmd_i.res_load) begin
      out_data_q   <= res_rd_q ? psu_pkg::DATA_W'(rdata_s) : '0;
      out_status_q <= res_st_q;
      out_fill_q   <= psu_pkg::FILL_W'(count_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;
  assign out_fill_o   = out_fill_q;

endmodule

>>> src/psu_ctrl.sv
// controller: state machine that sequences each request through the datapath
module psu_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  psu_pkg::stat_t stat_i,
  output psu_pkg::cmd_t  cmd_o
);

  psu_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psu_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      psu_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = psu_pkg::S_DECODE;
        end
      end
      psu_pkg::S_DECODE: begin
        cmd_o.set_status = 1'b1;
        cmd_o.status     = psu_pkg::ST_OK;
        state_d          = psu_pkg::S_RESULT;
        case (stat_i.op)
          psu_pkg::OP_PUSH_TOP: begin
            if (stat_i.full) begin
              cmd_o.status = psu_pkg::ST_FULL;
            end else begin
              cmd_o.mem_wr  = 1'b1;
              cmd_o.wr_sel  = psu_pkg::WR_VAL_TOP;
              cmd_o.cnt_inc = 1'b1;
            end
          end
          psu_pkg::OP_POP_TOP: begin
            if (stat_i.empty) begin
              cmd_o.status = psu_pkg::ST_EMPTY;
            end else begin
              cmd_o.cnt_dec = 1'b1;
            end
          end
          psu_pkg::OP_PUSH_BOTTOM: begin
            if (stat_i.full) begin
              cmd_o.status = psu_pkg::ST_FULL;
            end else begin
              cmd_o.ptr_init_top = 1'b1;
              state_d            = psu_pkg::S_UP_RD;
            end
          end
          psu_pkg::OP_POP_BOTTOM: begin
            if (stat_i.empty) begin
              cmd_o.status = psu_pkg::ST_EMPTY;
            end else begin
              cmd_o.ptr_init_idx = 1'b1;
              state_d            = psu_pkg::S_DN_RD;
            end
          end
          psu_pkg::OP_INSERT_AT: begin
            if (!stat_i.pos_ok) begin
              cmd_o.status = psu_pkg::ST_BADPOS;
            end else if (stat_i.full) begin
              cmd_o.status = psu_pkg::ST_FULL;
            end else begin
              cmd_o.ptr_init_top = 1'b1;
              state_d            = psu_pkg::S_UP_RD;
            end
          end
          psu_pkg::OP_DELETE_AT: begin
            if (stat_i.empty) begin
              cmd_o.status = psu_pkg::ST_EMPTY;
            end else if (!stat_i.pos_ok) begin
              cmd_o.status = psu_pkg::ST_BADPOS;
            end else begin
              cmd_o.ptr_init_idx = 1'b1;
              state_d            = psu_pkg::S_DN_RD;
            end
          end
          psu_pkg::OP_READ_AT: begin
            if (stat_i.empty) begin
              cmd_o.status = psu_pkg::ST_EMPTY;
            end else if (!stat_i.pos_ok) begin
              cmd_o.status    = psu_pkg::ST_BADPOS;
              cmd_o.mem_rd    = 1'b1;
              cmd_o.rd_sel    = psu_pkg::RD_TOP;
              cmd_o.use_rdata = 1'b1;
            end else begin
              cmd_o.mem_rd    = 1'b1;
              cmd_o.rd_sel    = psu_pkg::RD_IDX;
              cmd_o.use_rdata = 1'b1;
            end
          end
          psu_pkg::OP_READ_BOTTOM: begin
            if (stat_i.empty) begin
              cmd_o.status = psu_pkg::ST_EMPTY;
            end else begin
              cmd_o.mem_rd    = 1'b1;
              cmd_o.rd_sel    = psu_pkg::RD_IDX;
              cmd_o.use_rdata = 1'b1;
            end
          end
          default: begin
            cmd_o.status = psu_pkg::ST_OK;
          end
        endcase
      end
      // open a gap at the insert slot, top word first
      psu_pkg::S_UP_RD: begin
        if (stat_i.up_more) begin
          cmd_o.mem_rd = 1'b1;
          cmd_o.rd_sel = psu_pkg::RD_BELOW;
          state_d      = psu_pkg::S_UP_WR;
        end else begin
          cmd_o.mem_wr  = 1'b1;
          cmd_o.wr_sel  = psu_pkg::WR_VAL_IDX;
          cmd_o.cnt_inc = 1'b1;
          state_d       = psu_pkg::S_RESULT;
        end
      end
      psu_pkg::S_UP_WR: begin
        cmd_o.mem_wr  = 1'b1;
        cmd_o.wr_sel  = psu_pkg::WR_MOVE;
        cmd_o.ptr_dec = 1'b1;
        state_d       = psu_pkg::S_UP_RD;
      end
      // close the gap left by a removed word
      psu_pkg::S_DN_RD: begin
        if (stat_i.dn_more) begin
          cmd_o.mem_rd = 1'b1;
          cmd_o.rd_sel = psu_pkg::RD_ABOVE;
          state_d      = psu_pkg::S_DN_WR;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = psu_pkg::S_RESULT;
        end
      end
      psu_pkg::S_DN_WR: begin
        cmd_o.mem_wr  = 1'b1;
        cmd_o.wr_sel  = psu_pkg::WR_MOVE;
        cmd_o.ptr_inc = 1'b1;
        state_d       = psu_pkg::S_DN_RD;
      end
      psu_pkg::S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = psu_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = psu_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> src/positional_stack_unit.sv
// top level of the positional stack unit: controller, datapath and checks
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: value, position; tuser: opcode
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: read_data, status, fill_count
//
// one request at a time; push_top, pop_top and the reads go from accept through the
// decode and result states, shifting operations add a read state and a write state per
// word moved, as each move is one read and one write on the single slot memory port pair
// the result sits in an output register, so a new request is taken while it waits
// reset clears the count and the result valid; slot contents are not cleared
module positional_stack_unit #(
  parameter int unsigned DEPTH = psu_pkg::DEPTH_DEF,
  parameter int unsigned WIDTH = psu_pkg::WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // value [31:0], position [38:32]
  input  logic [2:0]  s_axis_tuser,  // opcode [2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // read_data [31:0], status [33:32], fill_count [40:34]
);

  psu_pkg::cmd_t                cmd;
  psu_pkg::stat_t               stat;
  logic [psu_pkg::DATA_W-1:0]   out_data;
  psu_pkg::status_e             out_status;
  logic [psu_pkg::FILL_W-1:0]   out_fill;

  psu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  psu_dp #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_op_i      (psu_pkg::op_e'(s_axis_tuser[2:0])),
    .in_value_i   (s_axis_tdata[31:0]),
    .in_pos_i     (s_axis_tdata[38:32]),
    .out_ready_i  (m_axis_tready),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_data_o   (out_data),
    .out_status_o (out_status),
    .out_fill_o   (out_fill)
  );

  assign m_axis_tdata = {7'd0, out_fill, out_status, out_data};

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending result overwritten");

  a_no_grow_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cnt_inc |-> !stat.full)
    else $error("count grows past depth");

  a_no_shrink_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cnt_dec |-> !stat.empty)
    else $error("count shrinks below zero");

endmodule

>>> tb/sv/tb_top.sv
// testbench for the positional stack unit: directed and random requests checked against a predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psu_pkg::*;

  localparam int DEPTH = DEPTH_DEF;

  typedef struct packed {
    logic [31:0] data;
    status_e     st;
    logic [6:0]  fill;
  } stack_result_t;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_CHURN} mix_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // value [31:0], position [38:32]
  logic [2:0]  s_axis_tuser = '0;  // opcode [2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // read_data [31:0], status [33:32], fill_count [40:34]

  positional_stack_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0]   stack_words [DEPTH];
  int            stack_fill;
  stack_result_t pending_results [$];

  bit idle_en = 1'b1;
  int errors;
  int requests_sent;
  int results_seen;
  int op_hits [8];
  int status_hits [4];
  int peak_fill;

  function automatic void insert_word(int idx, logic [31:0] w);
    for (int i = stack_fill; i > idx; i--) stack_words[i] = stack_words[i-1];
    stack_words[idx] = w;
    stack_fill++;
  endfunction

  function automatic void remove_word(int idx);
    for (int i = idx; i + 1 < stack_fill; i++) stack_words[i] = stack_words[i+1];
    stack_fill--;
  endfunction

  function automatic stack_result_t apply_stack_op(op_e op, logic [31:0] val, logic [6:0] pos);
    stack_result_t r;
    bit            pos_ok;
    r.data = '0;
    r.st   = ST_OK;
    pos_ok = (pos >= 1) && (int'(pos) <= stack_fill);
    case (op)
      OP_PUSH_TOP: begin
        if (stack_fill >= DEPTH) r.st = ST_FULL;
        else insert_word(stack_fill, val);
      end
      OP_POP_TOP: begin
        if (stack_fill == 0) r.st = ST_EMPTY;
        else stack_fill--;
      end
      OP_PUSH_BOTTOM: begin
        if (stack_fill >= DEPTH) r.st = ST_FULL;
        else insert_word(0, val);
      end
      OP_POP_BOTTOM: begin
        if (stack_fill == 0) r.st = ST_EMPTY;
        else remove_word(0);
      end
      OP_INSERT_AT: begin
        if (!pos_ok) r.st = ST_BADPOS;
        else if (stack_fill >= DEPTH) r.st = ST_FULL;
        else insert_word(int'(pos) - 1, val);
      end
      OP_DELETE_AT: begin
        if (stack_fill == 0) r.st = ST_EMPTY;
        else if (!pos_ok) r.st = ST_BADPOS;
        else remove_word(int'(pos) - 1);
      end
      OP_READ_AT: begin
        if (stack_fill == 0) begin
          r.st = ST_EMPTY;
        end else if (!pos_ok) begin
          r.st   = ST_BADPOS;
          r.data = stack_words[stack_fill-1];
        end else begin
          r.data = stack_words[int'(pos)-1];
        end
      end
      default: begin
        if (stack_fill == 0) r.st = ST_EMPTY;
        else r.data = stack_words[0];
      end
    endcase
    r.fill = stack_fill[6:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(op_e op, logic [31:0] val, logic [6:0] pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, pos, val};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(apply_stack_op(op, val, pos));
    op_hits[op]++;
    requests_sent++;
    if (stack_fill > peak_fill) peak_fill = stack_fill;
  endtask

  // receiver stalls
  initial begin
    int run;
    int gap;
    @(posedge rst_ni);
    forever begin
      run = $urandom_range(1, 12);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    stack_result_t exp_r;
    stack_result_t got_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_r.data = m_axis_tdata[31:0];
      got_r.st   = status_e'(m_axis_tdata[33:32]);
      got_r.fill = m_axis_tdata[40:34];
      results_seen++;
      status_hits[got_r.st]++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result data %h status %0d fill %0d",
                 $time, got_r.data, got_r.st, got_r.fill);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got_r.data !== exp_r.data) begin
          $display("%0t: read_data expected %h got %h", $time, exp_r.data, got_r.data);
          errors++;
        end
        if (got_r.st !== exp_r.st) begin
          $display("%0t: status expected %0d got %0d", $time, exp_r.st, got_r.st);
          errors++;
        end
        if (got_r.fill !== exp_r.fill) begin
          $display("%0t: fill_count expected %0d got %0d", $time, exp_r.fill, got_r.fill);
          errors++;
        end
      end
    end
  end

  task automatic test_empty_store();
    send_request(OP_POP_TOP, 32'h1234_5678, 7'd1);
    send_request(OP_POP_BOTTOM, 32'h0, 7'd0);
    send_request(OP_DELETE_AT, 32'h0, 7'd1);
    send_request(OP_READ_AT, 32'h0, 7'd0);
    send_request(OP_READ_BOTTOM, 32'h0, 7'd64);
    send_request(OP_INSERT_AT, 32'hdead_beef, 7'd1);
  endtask

  task automatic test_edge_values();
    send_request(OP_PUSH_TOP, 32'h7fff_ffff, 7'd0);
    send_request(OP_PUSH_BOTTOM, 32'h8000_0000, 7'd0);
    send_request(OP_PUSH_TOP, 32'hffff_ffff, 7'd127);
    send_request(OP_PUSH_TOP, 32'h0000_0000, 7'd0);
    send_request(OP_INSERT_AT, 32'h5a5a_a5a5, 7'd2);
    send_request(OP_INSERT_AT, 32'h1111_1111, 7'd0);
    send_request(OP_INSERT_AT, 32'h2222_2222, 7'd6);
    send_request(OP_READ_AT, 32'h0, 7'd1);
    send_request(OP_READ_AT, 32'h0, 7'd5);
    send_request(OP_READ_AT, 32'h0, 7'd64);
    send_request(OP_READ_AT, 32'h0, 7'd0);
    send_request(OP_READ_BOTTOM, 32'h0, 7'd0);
    send_request(OP_DELETE_AT, 32'h0, 7'd2);
    send_request(OP_DELETE_AT, 32'h0, 7'd0);
    send_request(OP_DELETE_AT, 32'h0, 7'd5);
    send_request(OP_POP_BOTTOM, 32'h0, 7'd0);
    send_request(OP_POP_TOP, 32'h0, 7'd0);
    send_request(OP_READ_AT, 32'h0, 7'd2);
  endtask

  task automatic test_full_store();
    while (stack_fill < DEPTH) begin
      if ($urandom_range(0, 1)) send_request(OP_PUSH_TOP, $urandom, 7'($urandom_range(0, 64)));
      else send_request(OP_PUSH_BOTTOM, $urandom, 7'($urandom_range(0, 64)));
    end
    send_request(OP_PUSH_TOP, 32'h0bad_0bad, 7'd0);
    send_request(OP_PUSH_BOTTOM, 32'h0bad_0bad, 7'd0);
    send_request(OP_INSERT_AT, 32'h0bad_0bad, 7'd64);
    send_request(OP_INSERT_AT, 32'h0bad_0bad, 7'd1);
    send_request(OP_INSERT_AT, 32'h0bad_0bad, 7'd0);
    send_request(OP_READ_AT, 32'h0, 7'd64);
    send_request(OP_READ_BOTTOM, 32'h0, 7'd0);
    send_request(OP_DELETE_AT, 32'h0, 7'd64);
    send_request(OP_DELETE_AT, 32'h0, 7'd1);
    send_request(OP_INSERT_AT, 32'hc0de_c0de, 7'd32);
    send_request(OP_READ_AT, 32'h0, 7'd32);
  endtask

  task automatic test_random_mix(int n_items);
    mix_e mix;
    int   left;
    int   r;
    op_e  op;
    logic [31:0] val;
    logic [6:0]  pos;
    left = 0;
    mix  = MIX_CHURN;
    for (int n = 0; n < n_items; n++) begin
      if (left == 0) begin
        mix     = mix_e'($urandom_range(0, 2));
        left    = $urandom_range(30, 90);
        idle_en = ($urandom_range(0, 3) != 0);
      end
      left--;
      r = $urandom_range(0, 99);
      if (mix == MIX_GROW && r < 55) begin
        case ($urandom_range(0, 2))
          0: op = OP_PUSH_TOP;
          1: op = OP_PUSH_BOTTOM;
          default: op = OP_INSERT_AT;
        endcase
      end else if (mix == MIX_SHRINK && r < 55) begin
        case ($urandom_range(0, 2))
          0: op = OP_POP_TOP;
          1: op = OP_POP_BOTTOM;
          default: op = OP_DELETE_AT;
        endcase
      end else begin
        op = op_e'($urandom_range(0, 7));
      end
      r = $urandom_range(0, 99);
      if (r < 4) val = 32'h8000_0000;
      else if (r < 8) val = 32'h7fff_ffff;
      else if (r < 11) val = 32'hffff_ffff;
      else if (r < 13) val = 32'h0;
      else val = $urandom;
      r = $urandom_range(0, 99);
      if (r < 75 && stack_fill > 0) pos = 7'($urandom_range(1, stack_fill));
      else if (r < 83) pos = 7'd0;
      else if (r < 90) pos = 7'(stack_fill + 1);
      else pos = 7'($urandom_range(0, 64));
      send_request(op, val, pos);
    end
    idle_en = 1'b1;
  endtask

  task automatic finish_run();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("ran %0d requests, %0d results checked, peak fill %0d of %0d",
             requests_sent, results_seen, peak_fill, DEPTH);
    $display("status counts: ok %0d, empty %0d, bad position %0d, full %0d",
             status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_BADPOS],
             status_hits[ST_FULL]);
    if (errors == 0) begin
      $display("[positional_stack_unit] OK");
    end else begin
      $display("[positional_stack_unit] ERROR");
    end
    $finish;
  endtask

  initial begin
    stack_fill = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_store();
    test_edge_values();
    test_full_store();
    test_random_mix(950 - requests_sent);
    finish_run();
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("[positional_stack_unit] ERROR");
    $finish;
  end

endmodule
